// ----- sv/msrh_pkg.sv -----
package msrh_pkg;

  localparam int COIL_NUMBER = 10;
  localparam int RSP_BYTES   = 9;
  localparam int LEN_W       = $clog2(RSP_BYTES + 1);
  localparam int CFG_ADDR_W  = 3;

  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REGISTER = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS    = 8'd15;

  localparam logic [7:0] EXC_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;
  localparam logic [7:0] EXC_RANGE    = 8'h10;
  localparam logic [7:0] EXC_FLAG     = 8'h80;

  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

  localparam logic [7:0] STD_DATA_LEN = 8'd4;
  localparam logic [7:0] MIN_MULTI_LEN = 8'd5;
  localparam int REG_STEP = 16;

  localparam logic CFG_COIL_BASE = 1'b0;
  localparam logic CFG_REG_BASE  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [7:0]  slave_address;
    logic [7:0]  data_length;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [7:0]  request_byte_count;
    logic [15:0] coil_data;
    logic [15:0] current_temperature;
  } req_t;

  typedef struct packed {
    logic [7:0]  response_byte;
    logic        last_byte;
    logic [9:0]  coil_outputs;
    logic [15:0] threshold_out;
    logic [15:0] duration_out;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } ctrl_status_t;

endpackage

// ----- sv/msrh_cfg.sv -----
module msrh_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msrh_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [15:0]                       coil_base,
  output logic [15:0]                       reg_base
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coil_base <= '0;
      reg_base  <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        msrh_pkg::CFG_COIL_BASE: coil_base <= pwdata[15:0];
        msrh_pkg::CFG_REG_BASE:  reg_base  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      msrh_pkg::CFG_COIL_BASE: prdata = {16'h0000, coil_base};
      msrh_pkg::CFG_REG_BASE:  prdata = {16'h0000, reg_base};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- sv/msrh_ctrl.sv -----
module msrh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  msrh_pkg::ctrl_status_t status,
  output msrh_pkg::ctrl_cmd_t    cmd
);

  msrh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msrh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      msrh_pkg::ST_IDLE: begin
        if (req_valid) state_next = msrh_pkg::ST_SEND;
      end
      msrh_pkg::ST_SEND: begin
        if (!rsp_stall && status.last) state_next = msrh_pkg::ST_IDLE;
      end
      default: state_next = msrh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = 1'b1;
    rsp_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state)
      msrh_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      msrh_pkg::ST_SEND: begin
        rsp_valid   = 1'b1;
        cmd.advance = !rsp_stall && !status.last;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/msrh_datapath.sv -----
module msrh_datapath #(
  parameter int COIL_NUMBER = msrh_pkg::COIL_NUMBER
) (
  input  logic                   clk,
  input  logic                   rst,
  input  msrh_pkg::ctrl_cmd_t    cmd,
  output msrh_pkg::ctrl_status_t status,
  input  msrh_pkg::req_t         req,
  input  logic [15:0]            coil_base,
  input  logic [15:0]            reg_base,
  output msrh_pkg::rsp_t         rsp
);

  localparam int OFF_W = (COIL_NUMBER > 1) ? $clog2(COIL_NUMBER) : 1;
  localparam int LW    = msrh_pkg::LEN_W;
  localparam logic [16:0] COIL_N17 = 17'(COIL_NUMBER);

  logic [COIL_NUMBER-1:0] coil, coil_next;
  logic [15:0]            thr, thr_next;
  logic [15:0]            dur, dur_next;

  logic [7:0]    rsp_buf [msrh_pkg::RSP_BYTES];
  logic [7:0]    buf_next [msrh_pkg::RSP_BYTES];
  logic [LW-1:0] rsp_len, len_next;
  logic [LW-1:0] idx;

  logic [16:0]      start17, qv17, cbase17, rbase17, coil_end;
  logic [15:0]      coil_diff;
  logic [OFF_W-1:0] off;
  logic             coil_bad_q, coil_bad_0;
  logic [15:0]      coil_wide, shifted, rd_bits, qmask, rev_data;
  logic [31:0]      mask_sh, data_sh;
  logic [2:0]       nb;
  logic [7:0]       rd_b0, rd_b1;
  logic             at_r0, at_r1, at_r2, reg_over;
  logic [1:0]       reg_off;
  logic [15:0]      rv0, rv1, rv2;
  logic             err;
  logic [7:0]       code;

  function automatic logic [15:0] get_reg(input logic [1:0] i, input logic [15:0] t,
                                          input logic [15:0] th, input logic [15:0] du);
    logic [15:0] v;
    case (i)
      2'd0:    v = t;
      2'd1:    v = th;
      2'd2:    v = du;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign start17    = {1'b0, req.start_address};
  assign qv17       = {1'b0, req.quantity_or_value};
  assign cbase17    = {1'b0, coil_base};
  assign rbase17    = {1'b0, reg_base};
  assign coil_end   = cbase17 + COIL_N17;
  assign coil_diff  = req.start_address - coil_base;
  assign off        = coil_diff[OFF_W-1:0];
  assign coil_bad_0 = (start17 < cbase17) || (start17 >= coil_end);
  assign coil_bad_q = coil_bad_0 || ((start17 + qv17) > coil_end);
  assign coil_wide  = 16'(coil);
  assign shifted    = coil_wide >> off;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      qmask[i]    = 17'(i) < qv17;
      rd_bits[i]  = shifted[i] & qmask[i];
      rev_data[i] = req.coil_data[15-i];
    end
    for (int i = 0; i < 8; i++) begin
      rd_b0[7-i] = rd_bits[i];
      rd_b1[7-i] = rd_bits[8+i];
    end
  end

  assign nb      = 3'((6'(req.quantity_or_value[4:0]) + 6'd7) >> 3);
  assign mask_sh = 32'(qmask) << off;
  assign data_sh = 32'(rev_data) << off;

  assign at_r0    = start17 == rbase17;
  assign at_r1    = start17 == rbase17 + 17'(msrh_pkg::REG_STEP);
  assign at_r2    = start17 == rbase17 + 17'(2 * msrh_pkg::REG_STEP);
  assign reg_over = (21'(start17) + 21'({req.quantity_or_value, 4'b0000}))
                    > (21'(rbase17) + 21'(3 * msrh_pkg::REG_STEP));
  assign reg_off  = at_r2 ? 2'd2 : (at_r1 ? 2'd1 : 2'd0);
  assign rv0      = get_reg(reg_off, req.current_temperature, thr, dur);
  assign rv1      = get_reg(reg_off + 2'd1, req.current_temperature, thr, dur);
  assign rv2      = get_reg(reg_off + 2'd2, req.current_temperature, thr, dur);

  always_comb begin
    for (int i = 0; i < msrh_pkg::RSP_BYTES; i++) buf_next[i] = '0;
    len_next  = '0;
    err       = 1'b0;
    code      = msrh_pkg::EXC_FUNCTION;
    coil_next = coil;
    thr_next  = thr;
    dur_next  = dur;
    buf_next[0] = req.slave_address;
    buf_next[1] = req.kind;
    case (req.kind)
      msrh_pkg::FC_READ_COILS: begin
        if (req.data_length != msrh_pkg::STD_DATA_LEN) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else if (coil_bad_q) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_ADDRESS;
        end else begin
          buf_next[2] = {5'b00000, nb};
          buf_next[3] = rd_b0;
          buf_next[4] = rd_b1;
          len_next    = LW'(3) + LW'(nb);
        end
      end
      msrh_pkg::FC_READ_HOLDING: begin
        if (req.data_length != msrh_pkg::STD_DATA_LEN) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else if (!(at_r0 || at_r1 || at_r2)) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_ADDRESS;
        end else if (reg_over) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_RANGE;
        end else begin
          buf_next[2] = {req.quantity_or_value[6:0], 1'b0};
          buf_next[3] = rv0[15:8];
          buf_next[4] = rv0[7:0];
          buf_next[5] = rv1[15:8];
          buf_next[6] = rv1[7:0];
          buf_next[7] = rv2[15:8];
          buf_next[8] = rv2[7:0];
          len_next    = LW'(3) + LW'({req.quantity_or_value[1:0], 1'b0});
        end
      end
      msrh_pkg::FC_WRITE_COIL: begin
        if (req.data_length != msrh_pkg::STD_DATA_LEN) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else if (coil_bad_0) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_ADDRESS;
        end else if (req.quantity_or_value != msrh_pkg::COIL_ON &&
                     req.quantity_or_value != msrh_pkg::COIL_OFF) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else begin
          if (req.quantity_or_value == msrh_pkg::COIL_ON) begin
            coil_next = coil | (COIL_NUMBER'(1) << off);
          end else begin
            coil_next = coil & ~(COIL_NUMBER'(1) << off);
          end
          len_next = LW'(6);
        end
      end
      msrh_pkg::FC_WRITE_REGISTER: begin
        if (req.data_length != msrh_pkg::STD_DATA_LEN) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else if (at_r1) begin
          thr_next = req.quantity_or_value;
          len_next = LW'(6);
        end else if (at_r2) begin
          dur_next = req.quantity_or_value;
          len_next = LW'(6);
        end else begin
          err  = 1'b1;
          code = msrh_pkg::EXC_ADDRESS;
        end
      end
      msrh_pkg::FC_WRITE_COILS: begin
        if (req.data_length < msrh_pkg::MIN_MULTI_LEN) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else if (coil_bad_q) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_ADDRESS;
        end else if ({5'b00000, nb} != req.request_byte_count) begin
          err  = 1'b1;
          code = msrh_pkg::EXC_VALUE;
        end else begin
          coil_next = (coil & ~mask_sh[COIL_NUMBER-1:0]) |
                      (data_sh[COIL_NUMBER-1:0] & mask_sh[COIL_NUMBER-1:0]);
          len_next  = LW'(6);
        end
      end
      default: begin
        err  = 1'b1;
        code = msrh_pkg::EXC_FUNCTION;
      end
    endcase
    if (len_next == LW'(6)) begin
      buf_next[2] = req.start_address[15:8];
      buf_next[3] = req.start_address[7:0];
      buf_next[4] = req.quantity_or_value[15:8];
      buf_next[5] = req.quantity_or_value[7:0];
    end
    if (err) begin
      buf_next[1] = req.kind | msrh_pkg::EXC_FLAG;
      buf_next[2] = code;
      len_next    = LW'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coil    <= '0;
      thr     <= '0;
      dur     <= '0;
      idx     <= '0;
      rsp_len <= '0;
    end else if (cmd.load) begin
      coil    <= coil_next;
      thr     <= thr_next;
      dur     <= dur_next;
      idx     <= '0;
      rsp_len <= len_next;
    end else if (cmd.advance) begin
      idx <= idx + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < msrh_pkg::RSP_BYTES; i++) rsp_buf[i] <= buf_next[i];
    end
  end

  assign status.last        = idx == (rsp_len - LW'(1));
  assign rsp.response_byte  = rsp_buf[idx];
  assign rsp.last_byte      = status.last;
  assign rsp.coil_outputs   = coil_wide[9:0];
  assign rsp.threshold_out  = thr;
  assign rsp.duration_out   = dur;

endmodule

// ----- sv/modbus_slave_request_handler.sv -----
// Request in, 3 to 9 response bytes out, one byte per cycle while rsp_stall is low.
// Response byte 0 is valid the cycle after the request is taken.
// A new request is taken only after the last response byte is accepted,
// paced by the byte counter that walks the response buffer.
// Reset (rst, synchronous): coils, threshold, duration and both base
// registers clear to zero; the handler comes up idle.
module modbus_slave_request_handler #(
  parameter int COIL_NUMBER = msrh_pkg::COIL_NUMBER
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  msrh_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output msrh_pkg::rsp_t                  rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msrh_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  msrh_pkg::ctrl_cmd_t    cmd;
  msrh_pkg::ctrl_status_t status;
  logic [15:0]            coil_base;
  logic [15:0]            reg_base;

  msrh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .coil_base (coil_base),
    .reg_base  (reg_base)
  );

  msrh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  msrh_datapath #(
    .COIL_NUMBER (COIL_NUMBER)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .coil_base (coil_base),
    .reg_base  (reg_base),
    .rsp       (rsp)
  );

endmodule
